// ===== hdl/set_assoc_writeback_lru_cache_defines.svh =====
// Assertion macros for the cache block.
// Used by the controller and top level; no other dependencies.
`ifndef SET_ASSOC_WRITEBACK_LRU_CACHE_DEFINES_SVH
`define SET_ASSOC_WRITEBACK_LRU_CACHE_DEFINES_SVH
`ifndef SYNTHESIS
`define SAC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SAC_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define SAC_ASSERT(label, clk, rst_n, prop)
`define SAC_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== hdl/sac_pkg.sv =====
// Shared types and command codes for the cache block.
// No dependencies.
package sac_pkg;

  // Byte address width of the main memory
  localparam int ADDR_BITS = 16;

  typedef struct packed {
    logic                 operation;
    logic [ADDR_BITS-1:0] address;
    logic [7:0]           write_data;
  } sac_req_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [63:0] line_data;
    logic        hit;
    logic        was_dirty;
  } sac_rsp_t;

  // Datapath command codes
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_LOOKUP,
    CMD_WB_BYTE,
    CMD_FILL_RD,
    CMD_FILL_WR,
    CMD_FINISH,
    CMD_CLEAR
  } sac_cmd_e;

  typedef struct packed {
    sac_cmd_e cmd;
  } sac_ctl_t;

  typedef struct packed {
    logic hit;
    logic dirty;
    logic is_write;
    logic last_byte;
    logic clear_last;
  } sac_sts_t;

endpackage

// ===== hdl/sac_datapath.sv =====
// Cache datapath: tag/line/dirty/age arrays, byte memory and line buffer.
// Depends on sac_pkg.
module sac_datapath #(
  parameter int NUM_SETS   = 16,
  parameter int NUM_WAYS   = 4,
  parameter int LINE_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sac_pkg::sac_req_t req_i,
  input  sac_pkg::sac_ctl_t ctl_i,
  output sac_pkg::sac_sts_t sts_o,
  output sac_pkg::sac_rsp_t rsp_o
);
  import sac_pkg::*;

  localparam int OB = $clog2(LINE_BYTES);
  localparam int SB = $clog2(NUM_SETS);
  localparam int WB = $clog2(NUM_WAYS);
  localparam int TB = ADDR_BITS - OB - SB;
  localparam int NE = NUM_SETS * NUM_WAYS;
  localparam int EB = $clog2(NE);
  localparam int MB = 1 << ADDR_BITS;
  localparam int OUTB = (LINE_BYTES < 8) ? LINE_BYTES : 8;

  // Per-set tag, dirty and age words in flops; one set is read per cycle
  logic [NUM_WAYS-1:0][TB-1:0] tag_q   [NUM_SETS];
  logic [NUM_WAYS-1:0]         dirty_q [NUM_SETS];
  logic [NUM_WAYS-1:0][WB-1:0] age_q   [NUM_SETS];
  // Line memory with row valid bits, byte memory cleared by a pass after reset
  logic [LINE_BYTES*8-1:0] line_mem [NE];
  logic [NE-1:0]           lvalid_q;
  logic [7:0]              mem [MB];

  logic [ADDR_BITS-1:0]    addr_q;
  logic                    wr_q;
  logic [7:0]              wdata_q;
  logic [LINE_BYTES*8-1:0] buf_q;
  logic [WB-1:0]           way_q;
  logic                    hit_q, vdirty_q;
  logic [TB-1:0]           vtag_q;
  logic [OB:0]             cnt_q;
  logic [ADDR_BITS-1:0]    clr_q;
  logic [7:0]              mrd_q;
  sac_rsp_t                rsp_q;

  logic [OB-1:0] off;
  logic [SB-1:0] set_idx;
  logic [TB-1:0] tag;
  assign off     = addr_q[OB-1:0];
  assign set_idx = addr_q[OB+SB-1:OB];
  assign tag     = addr_q[ADDR_BITS-1:OB+SB];

  // Words of the addressed set
  logic [NUM_WAYS-1:0][TB-1:0] set_tags;
  logic [NUM_WAYS-1:0]         set_dirty;
  logic [NUM_WAYS-1:0][WB-1:0] set_age;
  assign set_tags  = tag_q[set_idx];
  assign set_dirty = dirty_q[set_idx];
  assign set_age   = age_q[set_idx];

  // Way search and victim pick
  logic          hit_c;
  logic [WB-1:0] hway_c, vic_c, way_c;
  always_comb begin
    hit_c  = 1'b0;
    hway_c = '0;
    vic_c  = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (set_tags[w] == tag) begin
        hit_c  = 1'b1;
        hway_c = WB'(w);
      end
      if (set_age[w] > set_age[vic_c]) vic_c = WB'(w);
    end
    way_c = hit_c ? hway_c : vic_c;
  end

  // Age update: chosen way becomes youngest, younger ways age by one
  logic [NUM_WAYS-1:0][WB-1:0] age_upd_c;
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WB'(w) == way_c)
        age_upd_c[w] = '0;
      else if (set_age[w] < set_age[way_c])
        age_upd_c[w] = set_age[w] + 1'b1;
      else
        age_upd_c[w] = set_age[w];
    end
  end

  logic [EB-1:0] ent;
  assign ent = {set_idx, way_q};

  // Memory byte address for writeback or fill
  logic [ADDR_BITS-1:0] maddr;
  logic [OB-1:0]        ci;
  assign ci    = cnt_q[OB-1:0];
  assign maddr = (ctl_i.cmd == CMD_WB_BYTE) ? {vtag_q, set_idx, ci}
                                            : {tag, set_idx, ci};

  // Merged line for the final write
  logic [LINE_BYTES*8-1:0] fin_line;
  always_comb begin
    fin_line = buf_q;
    if (wr_q) fin_line[off*8 +: 8] = wdata_q;
  end

  logic [63:0] packed_c;
  always_comb begin
    packed_c = '0;
    packed_c[OUTB*8-1:0] = fin_line[OUTB*8-1:0];
  end

  // Line memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == CMD_LOOKUP)
      buf_q <= lvalid_q[{set_idx, way_c}] ? line_mem[{set_idx, way_c}] : '0;
    else if (ctl_i.cmd == CMD_FILL_WR)
      buf_q[ci*8 +: 8] <= mrd_q;
    if (ctl_i.cmd == CMD_FINISH) line_mem[ent] <= fin_line;
  end

  // Byte memory write port: clearing pass or writeback
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_wa;
  logic [7:0]           mem_wd;
  always_comb begin
    mem_we = 1'b0;
    mem_wa = maddr;
    mem_wd = buf_q[ci*8 +: 8];
    if (ctl_i.cmd == CMD_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = '0;
    end else if (ctl_i.cmd == CMD_WB_BYTE) begin
      mem_we = 1'b1;
    end
  end

  // Byte memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mrd_q <= mem[maddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q    <= '{default: '0};
      dirty_q  <= '{default: '0};
      lvalid_q <= '0;
      cnt_q    <= '0;
      clr_q    <= '0;
      addr_q   <= '0;
      wr_q     <= 1'b0;
      wdata_q  <= '0;
      way_q    <= '0;
      hit_q    <= 1'b0;
      vdirty_q <= 1'b0;
      vtag_q   <= '0;
      rsp_q    <= '0;
      for (int s = 0; s < NUM_SETS; s++)
        for (int w = 0; w < NUM_WAYS; w++) age_q[s][w] <= WB'(NUM_WAYS - 1 - w);
    end else begin
      unique case (ctl_i.cmd)
        CMD_CLEAR: clr_q <= clr_q + 1'b1;
        CMD_LOAD: begin
          addr_q  <= req_i.address;
          wr_q    <= req_i.operation;
          wdata_q <= req_i.write_data;
        end
        CMD_LOOKUP: begin
          way_q          <= way_c;
          hit_q          <= hit_c;
          vdirty_q       <= set_dirty[way_c];
          vtag_q         <= set_tags[way_c];
          cnt_q          <= '0;
          age_q[set_idx] <= age_upd_c;
        end
        CMD_WB_BYTE: begin
          cnt_q <= (cnt_q[OB-1:0] == OB'(LINE_BYTES - 1)) ? '0 : cnt_q + 1'b1;
        end
        CMD_FILL_RD: ;
        CMD_FILL_WR: cnt_q <= cnt_q + 1'b1;
        CMD_FINISH: begin
          tag_q[set_idx][way_q]   <= tag;
          dirty_q[set_idx][way_q] <= wr_q | (vdirty_q & hit_q);
          lvalid_q[ent]           <= 1'b1;
          rsp_q.read_byte <= fin_line[off*8 +: 8];
          rsp_q.line_data <= packed_c;
          rsp_q.hit       <= hit_q;
          rsp_q.was_dirty <= vdirty_q;
        end
        default: ;
      endcase
    end
  end

  assign sts_o.hit        = hit_q;
  assign sts_o.dirty      = vdirty_q;
  assign sts_o.is_write   = wr_q;
  assign sts_o.last_byte  = (cnt_q[OB-1:0] == OB'(LINE_BYTES - 1));
  assign sts_o.clear_last = (clr_q == '1);
  assign rsp_o = rsp_q;
endmodule

// ===== hdl/sac_ctrl.sv =====
// Cache controller state machine: sequences lookup, writeback, fill, finish.
// Depends on sac_pkg and the defines header.
`include "set_assoc_writeback_lru_cache_defines.svh"
module sac_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  sac_pkg::sac_sts_t sts_i,
  output sac_pkg::sac_ctl_t ctl_o,
  output logic              busy,
  output logic              done_o
);
  import sac_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_DECIDE, ST_WB, ST_FRD, ST_FWR, ST_FIN, ST_OUT
  } state_e;

  state_e state_q;
  logic   done_q;

  always_comb begin
    ctl_o.cmd = CMD_NONE;
    unique case (state_q)
      ST_CLEAR:  ctl_o.cmd = CMD_CLEAR;
      ST_IDLE:   if (start) ctl_o.cmd = CMD_LOAD;
      ST_LOOKUP: ctl_o.cmd = CMD_LOOKUP;
      ST_DECIDE: ctl_o.cmd = CMD_NONE;
      ST_WB:     ctl_o.cmd = CMD_WB_BYTE;
      ST_FRD:    ctl_o.cmd = CMD_FILL_RD;
      ST_FWR:    ctl_o.cmd = CMD_FILL_WR;
      ST_FIN:    ctl_o.cmd = CMD_FINISH;
      ST_OUT:    ctl_o.cmd = CMD_NONE;
      default:   ctl_o.cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR:  if (sts_i.clear_last) state_q <= ST_IDLE;
        ST_IDLE:   if (start) state_q <= ST_LOOKUP;
        ST_LOOKUP: state_q <= ST_DECIDE;
        ST_DECIDE: begin
          if (sts_i.hit)        state_q <= ST_FIN;
          else if (sts_i.dirty) state_q <= ST_WB;
          else                  state_q <= ST_FRD;
        end
        ST_WB:  if (sts_i.last_byte) state_q <= ST_FRD;
        ST_FRD: state_q <= ST_FWR;
        ST_FWR: state_q <= sts_i.last_byte ? ST_FIN : ST_FRD;
        ST_FIN: begin
          state_q <= ST_OUT;
          done_q  <= !sts_i.is_write;
        end
        ST_OUT:  state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

  `SAC_ASSERT(a_done_after_fin, clk_i, rst_ni, done_q |-> $past(state_q == ST_FIN))
  `SAC_ASSERT(a_start_leaves_idle, clk_i, rst_ni, (state_q == ST_IDLE && start) |=> busy)
  `SAC_ASSERT_NEVER(a_no_done_on_write, clk_i, rst_ni, done_q && $past(sts_i.is_write))
endmodule

// ===== hdl/set_assoc_writeback_lru_cache.sv =====
// Top level of the write-back LRU cache: controller plus datapath.
// Depends on sac_pkg, sac_ctrl, sac_datapath and the defines header.
//
// A transaction is taken when start is high and busy is low. After reset,
// busy stays high while a clearing pass zeroes the byte-wide main memory.
// From the accepting edge busy stays high through the lookup, decide,
// finish and output states on a hit; a clean miss adds a fill of the line
// and a dirty miss a writeback of the victim line before the fill. The
// byte-wide main memory port sets the miss cost: writeback writes the
// victim line byte by byte, and fill reads then writes each byte. Reads
// report one result for a single cycle on done_o, in the last busy cycle;
// the receiver cannot stall, so it must take it then.
// Writes report nothing.
`include "set_assoc_writeback_lru_cache_defines.svh"
module set_assoc_writeback_lru_cache #(
  parameter int NUM_SETS   = 16,
  parameter int NUM_WAYS   = 4,
  parameter int LINE_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sac_pkg::sac_req_t req_i,
  output logic              done_o,
  output sac_pkg::sac_rsp_t rsp_o
);
  import sac_pkg::*;

  sac_ctl_t ctl;
  sac_sts_t sts;

  sac_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .sts_i(sts), .ctl_o(ctl), .busy, .done_o
  );

  sac_datapath #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .LINE_BYTES(LINE_BYTES)
  ) u_dp (
    .clk_i, .rst_ni, .req_i, .ctl_i(ctl), .sts_o(sts), .rsp_o
  );

  `SAC_ASSERT_NEVER(a_done_while_idle, clk_i, rst_ni, done_o && !$past(busy))
  `SAC_ASSERT(a_done_busy, clk_i, rst_ni, done_o |-> busy)
  `SAC_ASSERT_NEVER(a_rsp_known, clk_i, rst_ni, done_o && $isunknown(rsp_o))
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the 4-way write-back LRU cache.
// Depends on sac_pkg and set_assoc_writeback_lru_cache; keeps its own cache model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sac_pkg::*;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;
  localparam int   SLOW_CYCLES = 30;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  sac_req_t req_i = '0;
  logic     done_o;
  sac_rsp_t rsp_o;

  always #5 clk_i = ~clk_i;

  set_assoc_writeback_lru_cache u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  // Predictor state: 16 sets x 4 ways, flat index set*4+way
  logic [8:0]  tags   [64];
  logic [7:0]  lines  [64][8];
  logic        dirty  [64];
  logic [1:0]  rank   [64];
  logic [7:0]  mem    [65536];
  sac_rsp_t    read_queue[$];
  int          errors = 0;
  int          n_reads = 0, n_writes = 0, n_hits = 0, n_dirty = 0;
  int          idle_pct = 0;

  function automatic void model_reset();
    for (int i = 0; i < 64; i++) begin
      tags[i] = '0;
      dirty[i] = 1'b0;
      rank[i] = 2'(3 - (i % 4));
      for (int b = 0; b < 8; b++) lines[i][b] = '0;
    end
    for (int a = 0; a < 65536; a++) mem[a] = '0;
  endfunction

  // Apply one access to the model; queue the response for reads
  function automatic void predict_access(sac_req_t r);
    logic [8:0]  tg;
    logic [3:0]  st;
    logic [2:0]  off;
    int          base, way, victim, hit_way;
    logic [1:0]  old;
    logic [15:0] wb;
    sac_rsp_t    rsp;
    tg = r.address[15:7];
    st = r.address[6:3];
    off = r.address[2:0];
    base = int'(st) * 4;
    hit_way = -1;
    victim = 0;
    for (int w = 0; w < 4; w++) begin
      if (tags[base+w] == tg) hit_way = w;
      if (rank[base+w] > rank[base+victim]) victim = w;
    end
    way = (hit_way >= 0) ? hit_way : victim;
    rsp.hit = (hit_way >= 0);
    rsp.was_dirty = dirty[base+way];
    old = rank[base+way];
    for (int w = 0; w < 4; w++)
      if (rank[base+w] < old) rank[base+w]++;
    rank[base+way] = '0;
    if (!rsp.hit) begin
      if (dirty[base+way]) begin
        wb = {tags[base+way], st, 3'b000};
        for (int b = 0; b < 8; b++) mem[wb + 16'(b)] = lines[base+way][b];
        dirty[base+way] = 1'b0;
      end
      tags[base+way] = tg;
      for (int b = 0; b < 8; b++) lines[base+way][b] = mem[{r.address[15:3], 3'(b)}];
    end
    if (r.operation == OP_WRITE) begin
      dirty[base+way] = 1'b1;
      lines[base+way][off] = r.write_data;
      n_writes++;
    end else begin
      rsp.read_byte = lines[base+way][off];
      for (int b = 0; b < 8; b++) rsp.line_data[8*b +: 8] = lines[base+way][b];
      read_queue.push_back(rsp);
      n_reads++;
      if (rsp.hit) n_hits++;
      if (rsp.was_dirty) n_dirty++;
    end
  endfunction

  // Send one transaction; random idle before it, returns at the accepting edge
  task automatic send_access(logic op, logic [15:0] addr, logic [7:0] data);
    sac_req_t r;
    r.operation = op;
    r.address = addr;
    r.write_data = data;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predict_access(r);
  endtask

  // Response checker
  always @(posedge clk_i) begin
    sac_rsp_t e;
    if (rst_ni && done_o) begin
      if (read_queue.size() == 0) begin
        $error("unexpected response");
        errors++;
      end else begin
        e = read_queue.pop_front();
        if (rsp_o.read_byte !== e.read_byte) begin
          $error("read_byte exp %h got %h", e.read_byte, rsp_o.read_byte); errors++;
        end
        if (rsp_o.line_data !== e.line_data) begin
          $error("line_data exp %h got %h", e.line_data, rsp_o.line_data); errors++;
        end
        if (rsp_o.hit !== e.hit) begin
          $error("hit exp %b got %b", e.hit, rsp_o.hit); errors++;
        end
        if (rsp_o.was_dirty !== e.was_dirty) begin
          $error("was_dirty exp %b got %b", e.was_dirty, rsp_o.was_dirty); errors++;
        end
      end
    end
  end

  // Extremes, reset tag-zero hits, multi-way match, dirty eviction
  task automatic test_directed();
    send_access(OP_READ, 16'h0000, 8'h00);
    send_access(OP_READ, 16'h0007, 8'h00);
    send_access(OP_WRITE, 16'h0003, 8'hFF);
    send_access(OP_READ, 16'h0003, 8'h00);
    send_access(OP_READ, 16'hFFFF, 8'h00);
    send_access(OP_WRITE, 16'hFFF8, 8'hA5);
    // fill one set with 5 tags so a dirty line is evicted, then reread it
    for (int t = 1; t <= 5; t++) send_access(OP_WRITE, {9'(t), 4'h5, 3'(t)}, 8'(t * 17));
    send_access(OP_READ, {9'd1, 4'h5, 3'd1}, 8'h00);
    send_access(OP_WRITE, 16'h7FFF, 8'h5A);
    send_access(OP_READ, 16'h8000, 8'h00);
    send_access(OP_READ, 16'h7FF8, 8'h00);
    send_access(OP_WRITE, 16'h0040, 8'h81);
    send_access(OP_READ, 16'h0040, 8'h00);
  endtask

  // Mostly a small tag pool so sets see hits, evictions and writebacks
  task automatic test_random(int count, int pct);
    logic [15:0] a;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      a = 16'($urandom);
      if ($urandom_range(9) < 8) a[15:7] = 9'($urandom_range(5)) << $urandom_range(8);
      send_access(logic'($urandom_range(1)), a, 8'($urandom));
    end
  endtask

  initial begin
    model_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(170, 16);
    test_random(170, 74);
    test_random(170, 0);
    start <= 1'b0;
    for (int i = 0; i < 4 * SLOW_CYCLES && read_queue.size() != 0; i++) @(posedge clk_i);
    if (read_queue.size() != 0) begin
      $error("missing responses: %0d", read_queue.size());
      errors++;
    end
    repeat (SLOW_CYCLES) @(posedge clk_i);
    $display("Covered %0d reads (%0d hits, %0d dirty) and %0d writes.",
             n_reads, n_hits, n_dirty, n_writes);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
